### rtl/sfeps_pkg.sv
`timescale 1ns / 1ps

package sfeps_pkg;

	// Field widths fixed by the bus and the flash address space
	localparam int ADDR_W = 24;
	localparam int LEN_W  = 25;
	localparam int END_W  = 26;
	localparam int DATA_W = 8;
	localparam int CMD_W  = 2;
	localparam int CFG_W  = 25;

	localparam logic [LEN_W-1:0] MAX_LEN = 25'h100_0000;

	// Geometry defaults (powers of two)
	localparam int PAGE_BYTES_DEF   = 256;
	localparam int SECTOR_BYTES_DEF = 4096;

	// Job queue between front and back
	localparam int JOBQ_DEPTH = 4;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STATUS = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_FLASH_OFFSET = 1'b0;
	localparam logic [0:0] CFG_IMAGE_LENGTH = 1'b1;

	// Flash opcodes
	localparam logic [DATA_W-1:0] OP_WREN   = 8'h06;
	localparam logic [DATA_W-1:0] OP_SE     = 8'h20;
	localparam logic [DATA_W-1:0] OP_PP     = 8'h02;
	localparam logic [DATA_W-1:0] OP_RDSR   = 8'h05;
	localparam logic [DATA_W-1:0] OP_DUMMY  = 8'hFF;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ERASE_POLL,
		PH_PROG_DATA,
		PH_PROG_POLL
	} phase_t;

	typedef enum logic [2:0] {
		JOB_ERASE,      // WREN, SE + address, status poll
		JOB_PROG,       // WREN, PP + address
		JOB_FINISH,     // finish marker
		JOB_DATA,       // one data byte
		JOB_DATA_POLL,  // last data byte of a chunk, then status poll
		JOB_REPOLL      // one more status read
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [DATA_W-1:0]   value;
	} job_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] tx_byte;
		logic              byte_valid;
		logic              new_frame;
		logic              read_back;
		logic              finished;
		logic              last;
	} out_beat_t;

endpackage

### rtl/sfeps_front.sv
`timescale 1ns / 1ps

module sfeps_front import sfeps_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	input  logic             q_full,
	output logic             q_push,
	output job_t             q_job
);

	localparam int PAGE_W  = $clog2(PAGE_BYTES);
	localparam int CHUNK_W = PAGE_W + 1;
	localparam logic [END_W-1:0]   SECT_MASK = END_W'(SECTOR_BYTES - 1);
	localparam logic [END_W-1:0]   SECT_STEP = END_W'(SECTOR_BYTES);
	localparam logic [CHUNK_W-1:0] PAGE_SIZE = CHUNK_W'(PAGE_BYTES);

	logic [ADDR_W-1:0]  flash_offset_q;
	logic [LEN_W-1:0]   image_length_q;
	phase_t             phase_q, phase_d;
	logic [END_W-1:0]   erase_addr_q, erase_addr_d;
	logic [END_W-1:0]   erase_end_q, erase_end_d;
	logic [ADDR_W-1:0]  write_addr_q, write_addr_d;
	logic [LEN_W-1:0]   bytes_rem_q, bytes_rem_d;
	logic [CHUNK_W-1:0] chunk_rem_q, chunk_rem_d;

	logic               accept;
	logic [LEN_W-1:0]   len_sat;
	logic [END_W-1:0]   end_raw;
	logic [END_W-1:0]   start_ea;
	logic [END_W-1:0]   start_ee;
	logic [END_W-1:0]   next_ea;
	logic [ADDR_W-1:0]  wa_src;
	logic [LEN_W-1:0]   br_src;
	logic [CHUNK_W-1:0] room;
	logic [CHUNK_W-1:0] chunk_new;
	logic [CHUNK_W-1:0] chunk_dec;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_offset_q <= '0;
			image_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLASH_OFFSET: flash_offset_q <= cfg_data[ADDR_W-1:0];
				CFG_IMAGE_LENGTH: image_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Range arithmetic for a start
	assign len_sat  = (image_length_q > MAX_LEN) ? MAX_LEN : image_length_q;
	assign end_raw  = END_W'(flash_offset_q) + END_W'(len_sat) + SECT_MASK;
	assign start_ea = END_W'(flash_offset_q) & ~SECT_MASK;
	assign start_ee = end_raw & ~SECT_MASK;
	assign next_ea  = erase_addr_q + SECT_STEP;

	// Program chunk set-up, from the start values or the running state
	assign wa_src    = (phase_q == PH_IDLE) ? flash_offset_q : write_addr_q;
	assign br_src    = (phase_q == PH_IDLE) ? len_sat : bytes_rem_q;
	assign room      = PAGE_SIZE - CHUNK_W'(wa_src[PAGE_W-1:0]);
	assign chunk_new = (br_src < LEN_W'(room)) ? br_src[CHUNK_W-1:0] : room;
	assign chunk_dec = (chunk_rem_q != '0) ? chunk_rem_q - 1'b1 : chunk_rem_q;

	// Next state and job selection
	always_comb begin
		phase_d      = phase_q;
		erase_addr_d = erase_addr_q;
		erase_end_d  = erase_end_q;
		write_addr_d = write_addr_q;
		bytes_rem_d  = bytes_rem_q;
		chunk_rem_d  = chunk_rem_q;
		q_push       = 1'b0;
		q_job.kind   = JOB_FINISH;
		q_job.addr   = wa_src;
		q_job.value  = in_data.value;
		if (accept) begin
			priority if (in_data.command == CMD_START && phase_q == PH_IDLE) begin
				q_push       = 1'b1;
				erase_addr_d = start_ea;
				erase_end_d  = start_ee;
				write_addr_d = flash_offset_q;
				bytes_rem_d  = len_sat;
				chunk_rem_d  = '0;
				if (start_ea < start_ee) begin
					q_job.kind = JOB_ERASE;
					q_job.addr = start_ea[ADDR_W-1:0];
					phase_d    = PH_ERASE_POLL;
				end else if (len_sat == '0) begin
					q_job.kind = JOB_FINISH;
					phase_d    = PH_IDLE;
				end else begin
					q_job.kind  = JOB_PROG;
					chunk_rem_d = chunk_new;
					phase_d     = PH_PROG_DATA;
				end
			end else if (in_data.command == CMD_STATUS &&
					(phase_q == PH_ERASE_POLL || phase_q == PH_PROG_POLL)) begin
				q_push = 1'b1;
				if (in_data.value[0]) begin
					q_job.kind = JOB_REPOLL;
				end else if (phase_q == PH_ERASE_POLL && next_ea < erase_end_q) begin
					erase_addr_d = next_ea;
					q_job.kind   = JOB_ERASE;
					q_job.addr   = next_ea[ADDR_W-1:0];
				end else begin
					if (phase_q == PH_ERASE_POLL) begin
						erase_addr_d = next_ea;
					end
					if (bytes_rem_q == '0) begin
						q_job.kind = JOB_FINISH;
						phase_d    = PH_IDLE;
					end else begin
						q_job.kind  = JOB_PROG;
						chunk_rem_d = chunk_new;
						phase_d     = PH_PROG_DATA;
					end
				end
			end else if (in_data.command == CMD_DATA && phase_q == PH_PROG_DATA) begin
				q_push       = 1'b1;
				write_addr_d = write_addr_q + 1'b1;
				bytes_rem_d  = (bytes_rem_q != '0) ? bytes_rem_q - 1'b1 : bytes_rem_q;
				chunk_rem_d  = chunk_dec;
				if (chunk_dec == '0) begin
					q_job.kind = JOB_DATA_POLL;
					phase_d    = PH_PROG_POLL;
				end else begin
					q_job.kind = JOB_DATA;
				end
			end else begin
				// out-of-turn item: dropped
				q_push = 1'b0;
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			erase_addr_q <= '0;
			erase_end_q  <= '0;
			write_addr_q <= '0;
			bytes_rem_q  <= '0;
			chunk_rem_q  <= '0;
		end else begin
			phase_q      <= phase_d;
			erase_addr_q <= erase_addr_d;
			erase_end_q  <= erase_end_d;
			write_addr_q <= write_addr_d;
			bytes_rem_q  <= bytes_rem_d;
			chunk_rem_q  <= chunk_rem_d;
		end
	end

endmodule

### rtl/sfeps_jobq.sv
`timescale 1ns / 1ps

module sfeps_jobq import sfeps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

	job_t             slot_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(JOBQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	// Job storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/sfeps_back.sv
`timescale 1ns / 1ps

module sfeps_back import sfeps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_beat_t  out_q;
	out_beat_t  beat;
	logic       load;

	// Beat for the current position within the head job
	always_comb begin
		beat            = '0;
		beat.byte_valid = 1'b1;
		unique case (head_job.kind)
			JOB_ERASE: begin
				unique case (idx_q)
					3'd0: begin beat.tx_byte = OP_WREN;  beat.new_frame = 1'b1; end
					3'd1: begin beat.tx_byte = OP_SE;    beat.new_frame = 1'b1; end
					3'd2: beat.tx_byte = head_job.addr[23:16];
					3'd3: beat.tx_byte = head_job.addr[15:8];
					3'd4: beat.tx_byte = head_job.addr[7:0];
					3'd5: begin beat.tx_byte = OP_RDSR;  beat.new_frame = 1'b1; end
					default: begin
						beat.tx_byte   = OP_DUMMY;
						beat.read_back = 1'b1;
						beat.last      = 1'b1;
					end
				endcase
			end
			JOB_PROG: begin
				unique case (idx_q)
					3'd0: begin beat.tx_byte = OP_WREN; beat.new_frame = 1'b1; end
					3'd1: begin beat.tx_byte = OP_PP;   beat.new_frame = 1'b1; end
					3'd2: beat.tx_byte = head_job.addr[23:16];
					3'd3: beat.tx_byte = head_job.addr[15:8];
					default: begin
						beat.tx_byte = head_job.addr[7:0];
						beat.last    = 1'b1;
					end
				endcase
			end
			JOB_FINISH: begin
				beat.byte_valid = 1'b0;
				beat.finished   = 1'b1;
				beat.last       = 1'b1;
			end
			JOB_DATA: begin
				beat.tx_byte = head_job.value;
				beat.last    = 1'b1;
			end
			JOB_DATA_POLL: begin
				unique case (idx_q)
					3'd0: beat.tx_byte = head_job.value;
					3'd1: begin beat.tx_byte = OP_RDSR; beat.new_frame = 1'b1; end
					default: begin
						beat.tx_byte   = OP_DUMMY;
						beat.read_back = 1'b1;
						beat.last      = 1'b1;
					end
				endcase
			end
			JOB_REPOLL: begin
				beat.tx_byte   = OP_DUMMY;
				beat.read_back = 1'b1;
				beat.last      = 1'b1;
			end
			default: begin
				beat.byte_valid = 1'b0;
			end
		endcase
	end

	assign load = !out_valid_q || !out_stall;
	assign pop  = load && head_valid && beat.last;

	// Output register
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= beat.last ? 3'd0 : idx_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/spi_flash_erase_program_sequencer_top.sv
`timescale 1ns / 1ps

// An item's first output beat passes the job queue and then the output register.
// One input item per cycle unless the queue is full; each job leaves at one beat per
// cycle unless out_stall holds it, and the job queue (four jobs) lets the front run
// ahead while multi-beat jobs (erase, program header, a chunk's last byte) drain.
// Reset (arst_n low) clears the phase, counters, queue and output valid at once.
module spi_flash_erase_program_sequencer_top import sfeps_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_data
);

	logic q_full;
	logic q_push;
	job_t q_job;
	logic q_pop;
	logic q_head_valid;
	job_t q_head_job;

	sfeps_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	sfeps_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	sfeps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sfeps_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 150;
	localparam int HOLD_CYCLES   = 200;
	localparam longint TIMEOUT_NS = 5_000_000;

	localparam logic [31:0] PAGE   = PAGE_BYTES_DEF;
	localparam logic [31:0] SECTOR = SECTOR_BYTES_DEF;

	// The one command code the block never acts on
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [0:0]       cfg_index = CFG_FLASH_OFFSET;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_beat_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_beat_t        out_data;

	spi_flash_erase_program_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	// Sequencer prediction state; registers are latched into it at each start
	logic [ADDR_W-1:0] reg_offset = '0;
	logic [LEN_W-1:0]  reg_length = '0;
	phase_t            seq_phase = PH_IDLE;
	logic [31:0]       erase_at = '0;
	logic [31:0]       erase_stop = '0;
	logic [ADDR_W-1:0] prog_addr = '0;
	logic [LEN_W-1:0]  prog_left = '0;
	logic [31:0]       chunk_left = '0;

	out_beat_t step_beats[$];
	out_beat_t due_beats[$];

	int  errors = 0;
	int  live_items = 0;
	int  hold_left = 0;
	bit  idle_on = 1'b1;

	function automatic void emit_beat(input logic [7:0] tx, input logic valid,
			input logic frame, input logic rb, input logic fin);
		out_beat_t b;
		b.tx_byte    = tx;
		b.byte_valid = valid;
		b.new_frame  = frame;
		b.read_back  = rb;
		b.finished   = fin;
		b.last       = 1'b0;
		step_beats.push_back(b);
	endfunction

	function automatic void emit_addr(input logic [31:0] a);
		emit_beat(a[23:16], 1'b1, 1'b0, 1'b0, 1'b0);
		emit_beat(a[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
		emit_beat(a[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic void emit_poll();
		emit_beat(OP_RDSR, 1'b1, 1'b1, 1'b0, 1'b0);
		emit_beat(OP_DUMMY, 1'b1, 1'b0, 1'b1, 1'b0);
	endfunction

	function automatic void begin_erase();
		emit_beat(OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
		emit_beat(OP_SE, 1'b1, 1'b1, 1'b0, 1'b0);
		emit_addr(erase_at);
		emit_poll();
		seq_phase = PH_ERASE_POLL;
	endfunction

	// Next page chunk, or the finish marker once the image is written
	function automatic void begin_program();
		logic [31:0] room;
		if (prog_left == 0) begin
			emit_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
			seq_phase = PH_IDLE;
		end else begin
			room = PAGE - (32'(prog_addr) % PAGE);
			chunk_left = (32'(prog_left) < room) ? 32'(prog_left) : room;
			emit_beat(OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
			emit_beat(OP_PP, 1'b1, 1'b1, 1'b0, 1'b0);
			emit_addr(32'(prog_addr));
			seq_phase = PH_PROG_DATA;
		end
	endfunction

	// Advance the sequencer by one accepted beat; queue what it must send
	function automatic int step_sequencer(input in_beat_t beat);
		logic [31:0] len;
		logic [31:0] stop;
		out_beat_t   b;
		step_beats.delete();
		if (beat.command == CMD_START && seq_phase == PH_IDLE) begin
			len = (reg_length > MAX_LEN) ? 32'(MAX_LEN) : 32'(reg_length);
			stop = 32'(reg_offset) + len + SECTOR - 1;
			erase_at = 32'(reg_offset) - (32'(reg_offset) % SECTOR);
			erase_stop = stop - (stop % SECTOR);
			prog_addr = reg_offset;
			prog_left = len[LEN_W-1:0];
			chunk_left = '0;
			if (erase_at < erase_stop)
				begin_erase();
			else
				begin_program();
		end else if (beat.command == CMD_STATUS &&
				(seq_phase == PH_ERASE_POLL || seq_phase == PH_PROG_POLL)) begin
			if (beat.value[0]) begin
				emit_beat(OP_DUMMY, 1'b1, 1'b0, 1'b1, 1'b0);
			end else if (seq_phase == PH_ERASE_POLL) begin
				erase_at = erase_at + SECTOR;
				if (erase_at < erase_stop)
					begin_erase();
				else
					begin_program();
			end else begin
				begin_program();
			end
		end else if (beat.command == CMD_DATA && seq_phase == PH_PROG_DATA) begin
			emit_beat(beat.value, 1'b1, 1'b0, 1'b0, 1'b0);
			prog_addr = prog_addr + 1'b1;
			if (prog_left != 0)
				prog_left = prog_left - 1'b1;
			if (chunk_left != 0)
				chunk_left = chunk_left - 1;
			if (chunk_left == 0) begin
				emit_poll();
				seq_phase = PH_PROG_POLL;
			end
		end
		foreach (step_beats[i]) begin
			b = step_beats[i];
			b.last = (i == step_beats.size() - 1);
			due_beats.push_back(b);
		end
		return step_beats.size();
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	// Compare every accepted output beat against the oldest one due
	always @(posedge clk) begin : beat_check
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_beats.size() == 0) begin
				errors++;
				$display("%0t ns: expected no beat, got %h", $time, out_data);
			end else begin
				want = due_beats.pop_front();
				check_field("tx_byte", want.tx_byte, out_data.tx_byte);
				check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
				check_field("new_frame", 8'(want.new_frame), 8'(out_data.new_frame));
				check_field("read_back", 8'(want.read_back), 8'(out_data.read_back));
				check_field("finished", 8'(want.finished), 8'(out_data.finished));
				check_field("last", 8'(want.last), 8'(out_data.last));
			end
		end
	end

	// Receiver: long hold-off on request, otherwise occasional stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 6);
		end
	end

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
		in_beat_t beat;
		beat.command = cmd;
		beat.value = val;
		if (idle_on && $urandom_range(99) < 4) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (step_sequencer(beat) > 0)
			live_items++;
	endtask

	task automatic send_noise();
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] val;
		cmd = CMD_W'($urandom_range(0, 3));
		val = DATA_W'($urandom_range(0, 255));
		send_beat(cmd, val);
	endtask

	// Status byte from the flash: busy about a quarter of the time
	function automatic logic [DATA_W-1:0] status_byte();
		logic [DATA_W-1:0] s;
		s = DATA_W'($urandom_range(0, 255));
		s[0] = ($urandom_range(3) == 0);
		return s;
	endfunction

	task automatic wait_all_beats();
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] offset, input logic [LEN_W-1:0] length);
		wait_all_beats();
		cfg_we <= 1'b1;
		cfg_index <= CFG_FLASH_OFFSET;
		cfg_data <= CFG_W'(offset);
		@(posedge clk);
		reg_offset = offset;
		cfg_index <= CFG_IMAGE_LENGTH;
		cfg_data <= length;
		@(posedge clk);
		reg_length = length;
		cfg_we <= 1'b0;
	endtask

	// Play the flash side until the operation finishes, with some stray beats
	task automatic play_flash(input int noise_pct);
		while (seq_phase != PH_IDLE) begin
			if ($urandom_range(99) < noise_pct)
				send_noise();
			else if (seq_phase == PH_PROG_DATA)
				send_beat(CMD_DATA, DATA_W'($urandom_range(0, 255)));
			else
				send_beat(CMD_STATUS, status_byte());
		end
	endtask

	task automatic test_idle_noise();
		send_beat(CMD_STATUS, 8'h00);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_UNUSED, 8'hA5);
	endtask

	task automatic test_empty_images();
		// aligned: finish marker straight away
		configure(24'h000000, 25'd0);
		send_beat(CMD_START, 8'h00);
		// unaligned: one sector erased, then finish
		configure(24'h000123, 25'd0);
		send_beat(CMD_START, 8'hFF);
		send_beat(CMD_STATUS, 8'h01);
		send_beat(CMD_STATUS, 8'h00);
	endtask

	task automatic test_out_of_turn();
		configure(24'h0000FE, 25'd3);
		send_beat(CMD_START, 8'h00);
		send_beat(CMD_START, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_UNUSED, 8'h5A);
		send_beat(CMD_STATUS, 8'h01);
		send_beat(CMD_STATUS, 8'hFE);
		send_beat(CMD_STATUS, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'h55);
		send_beat(CMD_STATUS, 8'h00);
		send_beat(CMD_DATA, 8'h80);
		send_beat(CMD_STATUS, 8'hFF);
		send_beat(CMD_STATUS, 8'h00);
	endtask

	// Image straddling the top of flash: both erase and program wrap to zero
	task automatic test_address_wrap();
		configure(24'hFFFFFE, 25'd3);
		send_beat(CMD_START, 8'h00);
		play_flash(0);
	endtask

	// Registers written mid-erase must not disturb the running operation
	task automatic test_config_latch();
		configure(24'h000100, 25'd20);
		send_beat(CMD_START, 8'h00);
		send_beat(CMD_STATUS, 8'h03);
		configure(24'hABCDEF, 25'd5000);
		play_flash(0);
	endtask

	task automatic test_receiver_holdoff();
		configure(24'h020000, 25'd60);
		hold_left = HOLD_CYCLES;
		send_beat(CMD_START, 8'h00);
		play_flash(0);
	endtask

	task automatic test_no_idle_stream();
		configure(24'h0123F0, 25'd80);
		idle_on = 1'b0;
		send_beat(CMD_START, 8'h00);
		play_flash(0);
		wait_all_beats();
		idle_on = 1'b1;
	endtask

	task automatic test_random_images();
		logic [ADDR_W-1:0] offset;
		logic [LEN_W-1:0]  length;
		int pick;
		int goal;
		goal = live_items + RANDOM_ITEMS;
		while (live_items < goal) begin
			offset = ADDR_W'($urandom);
			pick = $urandom_range(99);
			if (pick >= 85)
				offset[23:8] = 16'hFFFF;
			else if (pick >= 70)
				offset[11:0] = 12'($urandom_range(4080, 4095));
			else if (pick >= 40)
				offset[7:0] = 8'($urandom_range(240, 255));
			pick = $urandom_range(99);
			if (pick < 65)
				length = LEN_W'($urandom_range(0, 20));
			else if (pick < 90)
				length = LEN_W'($urandom_range(21, 300));
			else
				length = LEN_W'(PAGE_BYTES_DEF - 1 + $urandom_range(0, 2));
			configure(offset, length);
			send_beat(CMD_START, DATA_W'($urandom_range(0, 255)));
			play_flash(8);
		end
	endtask

	// Oversized length at the top address: a few wrapped erases, left unfinished
	task automatic test_saturated_length();
		configure(24'hFFFFFF, 25'h1FF_FFFF);
		send_beat(CMD_START, 8'h00);
		send_beat(CMD_STATUS, 8'h01);
		repeat (5) send_beat(CMD_STATUS, status_byte());
		send_beat(CMD_STATUS, 8'h00);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_noise();
		test_empty_images();
		test_out_of_turn();
		test_address_wrap();
		test_config_latch();
		test_receiver_holdoff();
		test_no_idle_stream();
		test_random_images();
		test_saturated_length();
		wait_all_beats();
		@(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
rtl/sfeps_pkg.sv
rtl/sfeps_front.sv
rtl/sfeps_jobq.sv
rtl/sfeps_back.sv
rtl/spi_flash_erase_program_sequencer_top.sv
tb/sv/testbench.sv
